@@ rtl/bang_framed_command_parser_unit_assert.svh @@
// Assertion macros for the bang-framed command parser checker.
// Depends on nothing; included by the checker file.
`ifndef BANG_FRAMED_COMMAND_PARSER_UNIT_ASSERT_SVH
`define BANG_FRAMED_COMMAND_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define BFCP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion lbl failed");

// next-cycle implication
`define BFCP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion lbl failed");

`endif

@@ rtl/bfcp_pkg.sv @@
// Shared types and constants for the bang-framed command parser.
// No dependencies; used by every module of the block.
package bfcp_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned VALUE_W = 10;
   localparam int unsigned VMAX_W  = 10;
   localparam int unsigned BTN_W   = 7;
   localparam int unsigned LEN_W   = 11;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 11;

   localparam logic [BYTE_W-1:0] MARK_CHAR = 8'h21;

   typedef enum logic [KIND_W-1:0] {
      KIND_VOLUME     = 3'd0,
      KIND_BUTTON     = 3'd1,
      KIND_VOLUME_OOR = 3'd2,
      KIND_BAD_BUTTON = 3'd3,
      KIND_MALFORMED  = 3'd4,
      KIND_OVERFLOW   = 3'd5
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLUME_MAX  = 2'd0,
      CSR_BUTTON_MIN  = 2'd1,
      CSR_BUTTON_MAX  = 2'd2,
      CSR_FRAME_LIMIT = 2'd3
   } csr_index_type;

   localparam logic [VMAX_W-1:0] VOLUME_MAX_RESET  = 10'd100;
   localparam logic [BTN_W-1:0]  BUTTON_MIN_RESET  = 7'd1;
   localparam logic [BTN_W-1:0]  BUTTON_MAX_RESET  = 7'd4;
   localparam logic [LEN_W-1:0]  FRAME_LIMIT_RESET = 11'd1024;

   typedef struct packed {
      logic [VMAX_W-1:0] volume_max;
      logic [BTN_W-1:0]  button_min;
      logic [BTN_W-1:0]  button_max;
      logic [LEN_W-1:0]  frame_limit;
   } cfg_type;

   typedef struct packed {
      kind_type           kind;
      logic [VALUE_W-1:0] value;
   } event_type;

   typedef struct packed {
      logic      valid;
      event_type evt;
   } event_push_type;

endpackage

@@ rtl/bfcp_csr.sv @@
// Configuration registers of the bang-framed command parser.
// Depends on bfcp_pkg.
module bfcp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [bfcp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bfcp_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output bfcp_pkg::cfg_type                 cfg
);

   bfcp_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volume_max  <= bfcp_pkg::VOLUME_MAX_RESET;
         cfg_ff.button_min  <= bfcp_pkg::BUTTON_MIN_RESET;
         cfg_ff.button_max  <= bfcp_pkg::BUTTON_MAX_RESET;
         cfg_ff.frame_limit <= bfcp_pkg::FRAME_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (bfcp_pkg::csr_index_type'(csr_index))
            bfcp_pkg::CSR_VOLUME_MAX: begin
               cfg_ff.volume_max <= csr_write_data[bfcp_pkg::VMAX_W-1:0];
            end
            bfcp_pkg::CSR_BUTTON_MIN: begin
               cfg_ff.button_min <= csr_write_data[bfcp_pkg::BTN_W-1:0];
            end
            bfcp_pkg::CSR_BUTTON_MAX: begin
               cfg_ff.button_max <= csr_write_data[bfcp_pkg::BTN_W-1:0];
            end
            bfcp_pkg::CSR_FRAME_LIMIT: begin
               cfg_ff.frame_limit <= csr_write_data[bfcp_pkg::LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/bfcp_parser.sv @@
// Per-beat frame matcher: state registers and the next-state logic that emits one event.
// Depends on bfcp_pkg.
module bfcp_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [bfcp_pkg::BYTE_W-1:0]   rx_byte,
   input  bfcp_pkg::cfg_type             cfg,
   output bfcp_pkg::event_push_type      push
);

   typedef enum logic [2:0] {
      STEP_TAG0, STEP_TAG1, STEP_TAG2, STEP_COLON,
      STEP_PRE, STEP_DIG, STEP_POST, STEP_BAD
   } step_type;

   logic                           in_frame_ff, in_frame_in;
   step_type                       step_ff, step_in;
   logic                           is_button_ff, is_button_in;
   logic [1:0]                     digits_ff, digits_in;
   logic [bfcp_pkg::VALUE_W-1:0]   acc_ff, acc_in;
   logic [bfcp_pkg::LEN_W-1:0]     length_ff, length_in;

   logic                           is_mark, is_space, is_digit, digits_full;
   logic [bfcp_pkg::VALUE_W-1:0]   acc_next, btn_min_w, btn_max_w;

   assign is_mark  = (rx_byte == bfcp_pkg::MARK_CHAR);
   assign is_space = (rx_byte == 8'h20) || (rx_byte >= 8'h09 && rx_byte <= 8'h0D);
   assign is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
   assign digits_full = is_button_ff ? (digits_ff >= 2'd2) : (digits_ff >= 2'd3);
   assign acc_next = (acc_ff << 3) + (acc_ff << 1)
                   + {6'd0, rx_byte[3:0]};
   assign btn_min_w = {3'd0, cfg.button_min};
   assign btn_max_w = {3'd0, cfg.button_max};

   always_comb begin
      in_frame_in  = in_frame_ff;
      step_in      = step_ff;
      is_button_in = is_button_ff;
      digits_in    = digits_ff;
      acc_in       = acc_ff;
      length_in    = length_ff;
      push.valid     = 1'b0;
      push.evt.kind  = bfcp_pkg::KIND_MALFORMED;
      push.evt.value = '0;
      if (take) begin
         if (!in_frame_ff) begin
            if (is_mark) begin
               in_frame_in  = 1'b1;
               step_in      = STEP_TAG0;
               is_button_in = 1'b0;
               digits_in    = '0;
               acc_in       = '0;
               length_in    = 11'd1;
            end
         end else if (is_mark || length_ff >= cfg.frame_limit) begin
            push.valid = 1'b1;
            if (!is_mark) begin
               push.evt.kind = bfcp_pkg::KIND_OVERFLOW;
            end else if (step_ff == STEP_DIG || step_ff == STEP_POST) begin
               push.evt.value = acc_ff;
               if (is_button_ff) begin
                  push.evt.kind = (acc_ff >= btn_min_w && acc_ff <= btn_max_w) ?
                     bfcp_pkg::KIND_BUTTON : bfcp_pkg::KIND_BAD_BUTTON;
               end else begin
                  push.evt.kind = (acc_ff <= cfg.volume_max) ?
                     bfcp_pkg::KIND_VOLUME : bfcp_pkg::KIND_VOLUME_OOR;
               end
            end
            in_frame_in  = 1'b0;
            step_in      = STEP_TAG0;
            is_button_in = 1'b0;
            digits_in    = '0;
            acc_in       = '0;
            length_in    = '0;
         end else begin
            length_in = length_ff + 11'd1;
            unique case (step_ff)
               STEP_TAG0: begin
                  if (rx_byte == "A") begin
                     is_button_in = 1'b0;
                     step_in      = STEP_TAG1;
                  end else if (rx_byte == "B") begin
                     is_button_in = 1'b1;
                     step_in      = STEP_TAG1;
                  end else begin
                     step_in = STEP_BAD;
                  end
               end
               STEP_TAG1: begin
                  step_in = (rx_byte == (is_button_ff ? "T" : "D")) ? STEP_TAG2 : STEP_BAD;
               end
               STEP_TAG2: begin
                  step_in = (rx_byte == (is_button_ff ? "N" : "C")) ? STEP_COLON : STEP_BAD;
               end
               STEP_COLON: begin
                  step_in = (rx_byte == ":") ? STEP_PRE : STEP_BAD;
               end
               STEP_PRE, STEP_DIG: begin
                  if (is_space) begin
                     if (step_ff == STEP_DIG) begin
                        step_in = STEP_POST;
                     end
                  end else if (is_digit) begin
                     if (digits_full) begin
                        step_in = STEP_BAD;
                     end else begin
                        acc_in    = acc_next;
                        digits_in = digits_ff + 2'd1;
                        step_in   = STEP_DIG;
                     end
                  end else begin
                     step_in = STEP_BAD;
                  end
               end
               STEP_POST: begin
                  if (!is_space) begin
                     step_in = STEP_BAD;
                  end
               end
               STEP_BAD: begin
                  step_in = STEP_BAD;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         step_ff      <= STEP_TAG0;
         is_button_ff <= 1'b0;
         digits_ff    <= '0;
         acc_ff       <= '0;
         length_ff    <= '0;
      end else begin
         in_frame_ff  <= in_frame_in;
         step_ff      <= step_in;
         is_button_ff <= is_button_in;
         digits_ff    <= digits_in;
         acc_ff       <= acc_in;
         length_ff    <= length_in;
      end
   end

endmodule

@@ rtl/bfcp_out_buf.sv @@
// Result register with a skid entry for the event channel.
// Depends on bfcp_pkg.
module bfcp_out_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  bfcp_pkg::event_push_type  push,
   output logic                      full,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output bfcp_pkg::event_type       rsp_event
);

   logic                 out_valid_ff, skid_valid_ff;
   bfcp_pkg::event_type  out_ff, skid_ff;
   logic                 out_ready;

   assign out_ready = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            out_ff        <= skid_ff;
            skid_valid_ff <= push.valid;
            skid_ff       <= push.evt;
         end else begin
            out_valid_ff <= push.valid;
            out_ff       <= push.evt;
         end
      end else if (push.valid) begin
         skid_valid_ff <= 1'b1;
         skid_ff       <= push.evt;
      end
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_event = out_ff;

endmodule

@@ rtl/bang_framed_command_parser_unit.sv @@
// Bang-framed command parser: takes serial bytes, emits volume/button events per frame.
// Depends on bfcp_pkg, bfcp_csr, bfcp_parser and bfcp_out_buf.
//
// Usage:
//   req_ channel carries one received byte per beat (req_rx_byte). A beat is taken
//   when req_valid is high and req_stall low. One beat per cycle is sustained while
//   req_stall is low; the frame state update is combinational on the parser registers.
//   rsp_ channel carries one event beat (kind, value) for each closing '!' or
//   for a frame that runs past frame_limit. The event is registered in the result
//   register (via the skid entry while rsp_ stalls) before it shows on rsp_; bytes
//   that close no frame give none. A stalled rsp_ beat holds; one more event fits
//   in a skid entry, and req_stall rises only while that entry is occupied.
//   csr_ writes set volume_max, button_min, button_max and frame_limit by index;
//   write them only while the block is idle.
//   Synchronous reset clears the parser to hunting for '!', empties the
//   result buffer and restores the register defaults (100, 1, 4, 1024).
module bang_framed_command_parser_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bfcp_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bfcp_pkg::KIND_W-1:0]       rsp_event_kind,
   output logic [bfcp_pkg::VALUE_W-1:0]      rsp_event_value,
   input  logic                              csr_write_enable,
   input  logic [bfcp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bfcp_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   bfcp_pkg::cfg_type         cfg;
   bfcp_pkg::event_push_type  push;
   bfcp_pkg::event_type       rsp_event;
   logic                      full;
   logic                      take;

   assign req_stall = full;
   assign take      = req_valid && !full;

   bfcp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bfcp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_rx_byte),
      .cfg     (cfg),
      .push    (push)
   );

   bfcp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_event (rsp_event)
   );

   assign rsp_event_kind  = rsp_event.kind;
   assign rsp_event_value = rsp_event.value;

endmodule

@@ rtl/bfcp_checker.sv @@
// Port-level checks on the event channel of the bang-framed command parser.
// Depends on bfcp_pkg and bang_framed_command_parser_unit_assert.svh; bound to the top level.
`include "bang_framed_command_parser_unit_assert.svh"

module bfcp_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [bfcp_pkg::KIND_W-1:0]   rsp_event_kind,
   input  logic [bfcp_pkg::VALUE_W-1:0]  rsp_event_value
);

   `BFCP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `BFCP_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_event_kind) && $stable(rsp_event_value))
   `BFCP_ASSERT_IMPLY(a_kind_legal, clock, reset, rsp_valid, rsp_event_kind <= bfcp_pkg::KIND_OVERFLOW)
   `BFCP_ASSERT_IMPLY(a_zero_value, clock, reset, rsp_valid && (rsp_event_kind == bfcp_pkg::KIND_MALFORMED || rsp_event_kind == bfcp_pkg::KIND_OVERFLOW), rsp_event_value == '0)

endmodule

bind bang_framed_command_parser_unit bfcp_checker u_bfcp_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for bang_framed_command_parser_unit: table-driven frames, then random traffic.
// Each accepted byte is predicted in-bench; events are checked in order. Needs bfcp_pkg and the RTL.
module tb;
   import bfcp_pkg::*;

   localparam int unsigned GAP_PCT      = 18;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned PHASE_BYTES  = 65;
   localparam int unsigned NUM_PHASES   = 7;

   typedef enum logic [3:0] {
      POS_TAG0, POS_TAG1, POS_TAG2, POS_COLON, POS_LEAD, POS_DIGITS, POS_TRAIL, POS_BAD
   } parse_pos_type;

   typedef struct packed {
      logic                  is_cfg;
      logic                  checked;
      event_type             ev;
      logic [CSR_DATA_W-1:0] vmax;
      logic [CSR_DATA_W-1:0] bmin;
      logic [CSR_DATA_W-1:0] bmax;
      logic [CSR_DATA_W-1:0] flim;
   } plan_row_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KIND_W-1:0]     rsp_event_kind;
   logic [VALUE_W-1:0]    rsp_event_value;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   bang_framed_command_parser_unit dut (.*);

   // frame parser mirror
   logic               frm_open;
   parse_pos_type      pos;
   logic               btn_tag;
   logic [1:0]         ndigits;
   logic [VALUE_W-1:0] num;
   logic [LEN_W-1:0]   flen;
   logic [VMAX_W-1:0]  vol_max;
   logic [BTN_W-1:0]   id_min;
   logic [BTN_W-1:0]   id_max;
   logic [LEN_W-1:0]   len_cap;

   event_type    event_q [$];
   event_type    head_ev;
   plan_row_type plan_q [$];
   string        text_q [$];
   logic         gaps_on = 1'b1;
   int           fail_count = 0;
   int           bytes_sent = 0;
   int           events_checked = 0;
   int           settings_done = 0;
   int           idle_cycles = 0;
   int           kind_seen [6] = '{default: 0};

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic is_ws(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_dig(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [7:0] random_ws();
      case ($urandom_range(5))
         0: return 8'h20;
         1: return 8'h09;
         2: return 8'h0A;
         3: return 8'h0B;
         4: return 8'h0C;
         default: return 8'h0D;
      endcase
   endfunction

   task automatic clear_parse();
      frm_open = 1'b0;
      pos      = POS_TAG0;
      btn_tag  = 1'b0;
      ndigits  = '0;
      num      = '0;
      flen     = '0;
   endtask

   task automatic parse_byte(input logic [7:0] c, output logic fired, output event_type ev);
      logic [7:0] want;
      logic [1:0] dmax;
      fired    = 1'b0;
      ev.kind  = KIND_VOLUME;
      ev.value = '0;
      if (!frm_open) begin
         if (c == MARK_CHAR) begin
            clear_parse();
            frm_open = 1'b1;
            flen     = LEN_W'(1);
         end
      end else if (c == MARK_CHAR) begin
         fired = 1'b1;
         if (pos == POS_DIGITS || pos == POS_TRAIL) begin
            ev.value = num;
            if (btn_tag)
               ev.kind = (num >= id_min && num <= id_max) ? KIND_BUTTON : KIND_BAD_BUTTON;
            else
               ev.kind = (num <= vol_max) ? KIND_VOLUME : KIND_VOLUME_OOR;
         end else begin
            ev.kind = KIND_MALFORMED;
         end
         clear_parse();
      end else if (flen >= len_cap) begin
         fired   = 1'b1;
         ev.kind = KIND_OVERFLOW;
         clear_parse();
      end else begin
         flen = flen + 1'b1;
         dmax = btn_tag ? 2'd2 : 2'd3;
         case (pos)
            POS_TAG0: begin
               if (c == "A") begin
                  btn_tag = 1'b0;
                  pos     = POS_TAG1;
               end else if (c == "B") begin
                  btn_tag = 1'b1;
                  pos     = POS_TAG1;
               end else begin
                  pos = POS_BAD;
               end
            end
            POS_TAG1: begin
               want = btn_tag ? "T" : "D";
               pos  = (c == want) ? POS_TAG2 : POS_BAD;
            end
            POS_TAG2: begin
               want = btn_tag ? "N" : "C";
               pos  = (c == want) ? POS_COLON : POS_BAD;
            end
            POS_COLON: pos = (c == ":") ? POS_LEAD : POS_BAD;
            POS_LEAD, POS_DIGITS: begin
               if (is_ws(c)) begin
                  if (pos == POS_DIGITS) pos = POS_TRAIL;
               end else if (is_dig(c)) begin
                  if (ndigits >= dmax) begin
                     pos = POS_BAD;
                  end else begin
                     num     = VALUE_W'(num * 10 + (c - 8'h30));
                     ndigits = ndigits + 1'b1;
                     pos     = POS_DIGITS;
                  end
               end else begin
                  pos = POS_BAD;
               end
            end
            POS_TRAIL: if (!is_ws(c)) pos = POS_BAD;
            default: pos = POS_BAD;
         endcase
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic use_typed, input event_type typed_ev);
      logic      fired;
      event_type ev;
      while (gaps_on && $urandom_range(99) < GAP_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_byte(b, fired, ev);
      bytes_sent++;
      if (fired) event_q.insert(event_q.size(), use_typed ? typed_ev : ev);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (event_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] v0, input logic [CSR_DATA_W-1:0] v1,
                                 input logic [CSR_DATA_W-1:0] v2, input logic [CSR_DATA_W-1:0] v3);
      logic [CSR_DATA_W-1:0] vals [4];
      int i;
      vals[0] = v0;
      vals[1] = v1;
      vals[2] = v2;
      vals[3] = v3;
      wait_idle();
      for (i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= csr_index_type'(i);
         csr_write_data   <= vals[i];
         @(posedge clock);
         case (csr_index_type'(i))
            CSR_VOLUME_MAX:  vol_max = vals[i][VMAX_W-1:0];
            CSR_BUTTON_MIN:  id_min  = vals[i][BTN_W-1:0];
            CSR_BUTTON_MAX:  id_max  = vals[i][BTN_W-1:0];
            CSR_FRAME_LIMIT: len_cap = vals[i][LEN_W-1:0];
            default: ;
         endcase
      end
      csr_write_enable <= 1'b0;
      settings_done++;
   endtask

   task automatic plan_frame(input string text, input logic checked, input kind_type k,
                             input int v);
      plan_row_type r;
      r          = '0;
      r.checked  = checked;
      r.ev.kind  = k;
      r.ev.value = VALUE_W'(v);
      plan_q.insert(plan_q.size(), r);
      text_q.insert(text_q.size(), text);
   endtask

   task automatic plan_settings(input int v0, input int v1, input int v2, input int v3);
      plan_row_type r;
      r        = '0;
      r.is_cfg = 1'b1;
      r.vmax   = CSR_DATA_W'(v0);
      r.bmin   = CSR_DATA_W'(v1);
      r.bmax   = CSR_DATA_W'(v2);
      r.flim   = CSR_DATA_W'(v3);
      plan_q.insert(plan_q.size(), r);
      text_q.insert(text_q.size(), "");
   endtask

   task automatic send_random_frame();
      logic [7:0]  fb [$];
      int unsigned sel;
      int unsigned v;
      int          k;
      logic        btn;
      string       digits;
      repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)), 1'b0, '0);
      fb.insert(fb.size(), MARK_CHAR);
      sel = $urandom_range(99);
      if (sel < 10) begin
         repeat ($urandom_range(12)) fb.insert(fb.size(), 8'($urandom_range(255)));
         fb.insert(fb.size(), MARK_CHAR);
      end else if (sel < 16) begin
         fb.insert(fb.size(), "A");
         fb.insert(fb.size(), "D");
         fb.insert(fb.size(), "C");
         fb.insert(fb.size(), ":");
         repeat ($urandom_range(20, 60)) fb.insert(fb.size(), random_ws());
         fb.insert(fb.size(), MARK_CHAR);
      end else begin
         btn = 1'($urandom_range(1));
         if ($urandom_range(19) == 0) begin
            fb.insert(fb.size(), $urandom_range(1) ? "A" : "B");
            fb.insert(fb.size(), $urandom_range(1) ? "D" : "T");
            fb.insert(fb.size(), $urandom_range(1) ? "C" : "N");
         end else begin
            fb.insert(fb.size(), btn ? "B" : "A");
            fb.insert(fb.size(), btn ? "T" : "D");
            fb.insert(fb.size(), btn ? "N" : "C");
         end
         fb.insert(fb.size(), ":");
         repeat ($urandom_range(2)) fb.insert(fb.size(), random_ws());
         if (btn) begin
            case ($urandom_range(3))
               0: v = $urandom_range(99);
               1: v = 32'(id_min);
               2: v = 32'(id_max);
               default: v = 32'(id_max) + 1;
            endcase
            if (v > 99) v = 99;
         end else begin
            case ($urandom_range(3))
               0: v = $urandom_range(999);
               1: v = 32'(vol_max);
               2: v = 32'(vol_max) + 1;
               default: v = 0;
            endcase
            if (v > 999) v = 999;
         end
         digits = $sformatf("%0d", v);
         if ($urandom_range(9) == 0) digits = {"0", digits};
         for (k = 0; k < digits.len(); k++) fb.insert(fb.size(), digits[k]);
         repeat ($urandom_range(2)) fb.insert(fb.size(), random_ws());
         if ($urandom_range(9) == 0)
            fb.insert($urandom_range(1, fb.size() - 1), 8'($urandom_range(255)));
         fb.insert(fb.size(), MARK_CHAR);
      end
      foreach (fb[k]) send_byte(fb[k], 1'b0, '0);
   endtask

   always @(posedge clock) begin
      rsp_stall <= gaps_on && ($urandom_range(99) < GAP_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (event_q.size() == 0) begin
            report_mismatch($sformatf("event kind %0d value %0d with none expected",
                                      rsp_event_kind, rsp_event_value));
         end else begin
            head_ev = event_q.pop_front();
            events_checked++;
            kind_seen[int'(head_ev.kind)]++;
            if (rsp_event_kind !== head_ev.kind)
               report_mismatch($sformatf("event_kind got %0d want %0d",
                                         rsp_event_kind, head_ev.kind));
            if (rsp_event_value !== head_ev.value)
               report_mismatch($sformatf("event_value got %0d want %0d",
                                         rsp_event_value, head_ev.value));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[%0t] timeout: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      plan_row_type row;
      string        row_text;
      int           i;
      int           j;
      int           ph;
      int           start;

      clear_parse();
      vol_max = VOLUME_MAX_RESET;
      id_min  = BUTTON_MIN_RESET;
      id_max  = BUTTON_MAX_RESET;
      len_cap = FRAME_LIMIT_RESET;

      plan_frame("!ADC:0!", 1'b1, KIND_VOLUME, 0);
      plan_frame("!ADC:100!", 1'b1, KIND_VOLUME, 100);
      plan_frame("!ADC:101!", 1'b1, KIND_VOLUME_OOR, 101);
      plan_frame("!ADC: \t999 \r\n!", 1'b1, KIND_VOLUME_OOR, 999);
      plan_frame("!BTN:1!", 1'b1, KIND_BUTTON, 1);
      plan_frame("!BTN:04!", 1'b1, KIND_BUTTON, 4);
      plan_frame("!BTN:0!", 1'b1, KIND_BAD_BUTTON, 0);
      plan_frame("!BTN:99!", 1'b1, KIND_BAD_BUTTON, 99);
      plan_frame("!!", 1'b1, KIND_MALFORMED, 0);
      plan_frame("!ADC:!", 1'b1, KIND_MALFORMED, 0);
      plan_frame("!AD!", 1'b1, KIND_MALFORMED, 0);
      plan_frame("!ADC:1234!", 1'b1, KIND_MALFORMED, 0);
      plan_frame("!BTN:123!", 1'b1, KIND_MALFORMED, 0);
      plan_frame("!ADC:12 x!", 1'b1, KIND_MALFORMED, 0);
      plan_frame("!ATC:5!", 1'b1, KIND_MALFORMED, 0);
      plan_frame("!BDN:5!", 1'b1, KIND_MALFORMED, 0);
      plan_frame("\377junk!BTN:\013\0142\t!", 1'b0, KIND_VOLUME, 0);
      plan_frame("!ADC:7 \n 3!", 1'b0, KIND_VOLUME, 0);
      plan_settings(999, 50, 10, 1024);
      plan_frame("!BTN:30!", 1'b1, KIND_BAD_BUTTON, 30);
      plan_frame("!ADC:999!", 1'b1, KIND_VOLUME, 999);
      plan_settings(0, 0, 0, 0);
      plan_frame("!A", 1'b1, KIND_OVERFLOW, 0);
      plan_frame("!!", 1'b1, KIND_MALFORMED, 0);
      plan_settings(2047, 2047, 2047, 8);
      plan_frame("!ADC:  12!!", 1'b0, KIND_VOLUME, 0);
      plan_frame("!ADC:5 !", 1'b0, KIND_VOLUME, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(8'h00, 1'b0, '0);
      send_byte(8'hFF, 1'b0, '0);
      for (i = 0; i < plan_q.size(); i++) begin
         row = plan_q[i];
         if (row.is_cfg) begin
            apply_settings(row.vmax, row.bmin, row.bmax, row.flim);
         end else begin
            row_text = text_q[i];
            for (j = 0; j < row_text.len(); j++) send_byte(row_text[j], row.checked, row.ev);
         end
      end

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: apply_settings(999, 0, 99, 1024);
            1: apply_settings(0, 0, 0, 8);
            2: apply_settings(100, 1, 4, 1024);
            3: apply_settings(500, 60, 20, 12);
            4: apply_settings(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF);
            5: apply_settings(0, 0, 0, 0);
            default: apply_settings(CSR_DATA_W'($urandom_range(999)),
                                    CSR_DATA_W'($urandom_range(99)),
                                    CSR_DATA_W'($urandom_range(99)),
                                    CSR_DATA_W'($urandom_range(8, 64)));
         endcase
         gaps_on = (ph != 2);
         start   = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) send_random_frame();
      end

      gaps_on = 1'b1;
      wait_idle();
      $display("Run covered %0d bytes under %0d register settings; %0d events checked.",
               bytes_sent, settings_done, events_checked);
      $display("Events: volume %0d, button %0d, volume out of range %0d, bad button %0d, %s",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
               $sformatf("malformed %0d, overflow %0d", kind_seen[4], kind_seen[5]));
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
